>>> rtl/kect_pkg.sv
package kect_pkg;

  localparam int unsigned KECT_ENTRIES = 16;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned DATE_W  = 32;
  localparam int unsigned LIMIT_W = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

  localparam int unsigned S_TDATA_W = KEY_W + DATE_W;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = CNT_W + DATE_W;
  localparam int unsigned M_TUSER_W = 2;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [APB_ADDR_W-3:0] REG_TABLE_LIMIT = 1'b0;

  typedef enum logic {
    ACT_RECORD = 1'b0,
    ACT_QUERY  = 1'b1
  } action_e;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic [CNT_W-1:0]  count;
    logic [DATE_W-1:0] date;
  } entry_t;

  typedef struct packed {
    logic load;
    logic search;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic exhausted;
    logic out_free;
  } status_t;

endpackage

>>> rtl/keyed_event_count_table.sv
// Keyed event count table. Each item on the slave stream either records one event for a
// nonzero 32-bit key or queries that key; exactly one result item follows on the master
// stream with the hit flag, the count (saturating at 65535), the latest date and the sticky
// overflow flag. New keys are appended until the entry count reaches the smaller of
// table_limit and TABLE_ENTRIES; a further new key sets overflow and freezes the table
// until reset. The key store is a single-port-read memory searched one entry per cycle,
// followed by one update step, which waits for as long as the output register still holds
// a result that has not been taken.
// One item is worked on at a time, and a new item is taken while the previous result still
// waits in the output register.
module keyed_event_count_table #(
  parameter int unsigned TABLE_ENTRIES = kect_pkg::KECT_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // key [31:0], event_date [63:32]
  input  logic [kect_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  // action [0], update_date [1]
  input  logic [kect_pkg::S_TUSER_W-1:0]    s_axis_tuser,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // event_count [15:0], latest_date [47:16]
  output logic [kect_pkg::M_TDATA_W-1:0]    m_axis_tdata,
  // hit [0], overflowed [1]
  output logic [kect_pkg::M_TUSER_W-1:0]    m_axis_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [kect_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [kect_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [kect_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);
  import kect_pkg::*;

  logic [LIMIT_W-1:0] table_limit_q;
  logic               limit_sel, limit_we;
  cmd_t               cmd;
  status_t            st;

  assign pready    = 1'b1;
  assign limit_sel = paddr[APB_ADDR_W-1:2] == REG_TABLE_LIMIT;
  assign limit_we  = psel && penable && pwrite && pready && limit_sel;
  assign prdata    = limit_sel ? APB_DATA_W'(table_limit_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_limit_q <= LIMIT_RESET;
    end else if (limit_we) begin
      table_limit_q <= pwdata[LIMIT_W-1:0];
    end
  end

  kect_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .st_i          (st),
    .cmd_o         (cmd)
  );

  kect_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .table_limit_i (table_limit_q),
    .cmd_i         (cmd),
    .st_o          (st),
    .m_tvalid_o    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_o     (m_axis_tdata),
    .m_tuser_o     (m_axis_tuser)
  );

endmodule

>>> rtl/kect_ctrl.sv
module kect_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  kect_pkg::status_t st_i,
  output kect_pkg::cmd_t    cmd_o
);
  import kect_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_UPDATE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        cmd_o.search = 1'b1;
        if (st_i.match || st_i.exhausted) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (st_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SEARCH) && !st_i.match && !st_i.exhausted |=> (state_q == ST_SEARCH))
    else $error("search left without a match or the end of the table");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> st_i.out_free)
    else $error("result written while the output register is occupied");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == ST_SEARCH) && !s_axis_tready)
    else $error("new item taken while an item is in progress");

endmodule

>>> rtl/kect_dpath.sv
module kect_dpath #(
  parameter int unsigned TABLE_ENTRIES = kect_pkg::KECT_ENTRIES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic [kect_pkg::S_TDATA_W-1:0]    s_tdata_i,
  input  logic [kect_pkg::S_TUSER_W-1:0]    s_tuser_i,
  input  logic [kect_pkg::LIMIT_W-1:0]      table_limit_i,
  input  kect_pkg::cmd_t                    cmd_i,
  output kect_pkg::status_t                 st_o,
  output logic                              m_tvalid_o,
  input  logic                              m_tready_i,
  output logic [kect_pkg::M_TDATA_W-1:0]    m_tdata_o,
  output logic [kect_pkg::M_TUSER_W-1:0]    m_tuser_o
);
  import kect_pkg::*;

  localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned UW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CW = (UW > LIMIT_W) ? UW : LIMIT_W;

  entry_t mem_q [TABLE_ENTRIES];

  action_e           act_q;
  logic [KEY_W-1:0]  key_q;
  logic [DATE_W-1:0] date_q;
  logic              upd_q;

  logic [UW-1:0]     rd_idx_q, rd_idx_d;
  logic              pend_q, pend_d;
  logic [IW-1:0]     cmp_idx_q;
  entry_t            rd_data_q;

  logic              hit_q, hit_d;
  logic [IW-1:0]     hit_idx_q;
  logic [CNT_W-1:0]  hit_cnt_q;
  logic [DATE_W-1:0] hit_date_q;

  logic [UW-1:0]     used_q, used_d;
  logic              ovf_q, ovf_d;

  logic              out_valid_q, out_valid_d;
  logic              out_hit_q, out_ovf_q;
  logic [CNT_W-1:0]  out_cnt_q;
  logic [DATE_W-1:0] out_date_q;

  logic              issue, match, more;
  logic              skip, full;
  logic [CW-1:0]     limit_eff;
  logic              we;
  logic [IW-1:0]     waddr;
  entry_t            wentry;
  logic              res_hit;
  logic [CNT_W-1:0]  res_cnt, inc_cnt;
  logic [DATE_W-1:0] res_date, new_date;

  assign more  = rd_idx_q < used_q;
  assign issue = cmd_i.search && more;
  assign match = pend_q && (rd_data_q.key == key_q);

  assign st_o.match     = cmd_i.search && match;
  assign st_o.exhausted = cmd_i.search && !pend_q && !more;
  assign st_o.out_free  = !out_valid_q || m_tready_i;

  assign limit_eff = (CW'(table_limit_i) > CW'(TABLE_ENTRIES)) ? CW'(TABLE_ENTRIES)
                                                              : CW'(table_limit_i);
  assign full      = CW'(used_q) >= limit_eff;
  assign skip      = ovf_q || (key_q == '0);
  assign inc_cnt   = (hit_cnt_q == '1) ? hit_cnt_q : hit_cnt_q + CNT_W'(1);
  assign new_date  = (upd_q && (date_q > hit_date_q)) ? date_q : hit_date_q;

  always_comb begin
    rd_idx_d = rd_idx_q;
    pend_d   = pend_q;
    hit_d    = hit_q;
    if (cmd_i.load) begin
      rd_idx_d = '0;
      pend_d   = 1'b0;
      hit_d    = 1'b0;
    end else if (cmd_i.search) begin
      pend_d = issue;
      if (issue) begin
        rd_idx_d = rd_idx_q + UW'(1);
      end
      if (match) begin
        hit_d = 1'b1;
      end
    end
  end

  always_comb begin
    we           = 1'b0;
    waddr        = hit_idx_q;
    wentry.key   = key_q;
    wentry.count = inc_cnt;
    wentry.date  = new_date;
    res_hit      = 1'b0;
    res_cnt      = '0;
    res_date     = '0;
    used_d       = used_q;
    ovf_d        = ovf_q;
    if (cmd_i.finish && !skip) begin
      if (hit_q) begin
        res_hit = 1'b1;
        if (act_q == ACT_RECORD) begin
          we       = 1'b1;
          res_cnt  = inc_cnt;
          res_date = new_date;
        end else begin
          res_cnt  = hit_cnt_q;
          res_date = hit_date_q;
        end
      end else if (act_q == ACT_RECORD) begin
        if (full) begin
          ovf_d = 1'b1;
        end else begin
          we           = 1'b1;
          waddr        = used_q[IW-1:0];
          wentry.count = CNT_W'(1);
          wentry.date  = upd_q ? date_q : '0;
          used_d       = used_q + UW'(1);
          res_cnt      = CNT_W'(1);
          res_date     = wentry.date;
        end
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
    end else if (m_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q    <= '0;
      pend_q      <= 1'b0;
      hit_q       <= 1'b0;
      used_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      rd_idx_q    <= rd_idx_d;
      pend_q      <= pend_d;
      hit_q       <= hit_d;
      used_q      <= used_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q  <= s_tdata_i[KEY_W-1:0];
      date_q <= s_tdata_i[KEY_W+DATE_W-1:KEY_W];
      act_q  <= action_e'(s_tuser_i[0]);
      upd_q  <= s_tuser_i[1];
    end
    if (issue) begin
      rd_data_q <= mem_q[rd_idx_q[IW-1:0]];
      cmp_idx_q <= rd_idx_q[IW-1:0];
    end
    if (cmd_i.search && match) begin
      hit_idx_q  <= cmp_idx_q;
      hit_cnt_q  <= rd_data_q.count;
      hit_date_q <= rd_data_q.date;
    end
    if (we) begin
      mem_q[waddr] <= wentry;
    end
    if (cmd_i.finish) begin
      out_hit_q  <= res_hit;
      out_cnt_q  <= res_cnt;
      out_date_q <= res_date;
      out_ovf_q  <= ovf_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign m_tdata_o  = {out_date_q, out_cnt_q};
  assign m_tuser_o  = {out_ovf_q, out_hit_q};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CW'(used_q) <= CW'(TABLE_ENTRIES))
    else $error("entry count beyond the table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |=> ovf_q && $stable(used_q))
    else $error("table changed after overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && ovf_q |=> !out_hit_q && out_ovf_q && (out_cnt_q == '0))
    else $error("result after overflow is not empty");

endmodule

>>> tb/tb_top.sv
module tb_top;
  import kect_pkg::*;

  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned SETTLE_CYCLES = 2 * KECT_ENTRIES + 8;
  localparam int unsigned PRINT_LIMIT   = 40;
  localparam logic [APB_ADDR_W-1:0] LIMIT_ADDR = {REG_TABLE_LIMIT, 2'b00};

  typedef struct packed {
    action_e             action;
    logic [KEY_W-1:0]    key;
    logic [DATE_W-1:0]   event_date;
    logic                update_date;
  } event_item_t;

  typedef struct packed {
    logic                hit;
    logic [CNT_W-1:0]    count;
    logic [DATE_W-1:0]   date;
    logic                overflowed;
  } tally_t;

  typedef enum logic [1:0] {
    RX_FLOW,
    RX_THREE_IN_FOUR,
    RX_COIN,
    RX_BURSTY
  } rx_mode_e;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [S_TDATA_W-1:0]    s_axis_tdata = '0;
  logic [S_TUSER_W-1:0]    s_axis_tuser = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]    m_axis_tdata;
  logic [M_TUSER_W-1:0]    m_axis_tuser;
  logic                    psel = 1'b0;
  logic                    penable = 1'b0;
  logic                    pwrite = 1'b0;
  logic [APB_ADDR_W-1:0]   paddr = '0;
  logic [APB_DATA_W-1:0]   pwdata = '0;
  logic [APB_DATA_W-1:0]   prdata;
  logic                    pready;

  // Shadow copy of the table, kept in step with every accepted item.
  logic [KEY_W-1:0]        key_tbl [KECT_ENTRIES];
  logic [CNT_W-1:0]        cnt_tbl [KECT_ENTRIES];
  logic [DATE_W-1:0]       date_tbl [KECT_ENTRIES];
  int unsigned             used_cnt = 0;
  logic                    ovf_flag = 1'b0;
  logic [LIMIT_W-1:0]      limit_reg = LIMIT_RESET;

  tally_t                  tally_q [$];
  int unsigned             err_count = 0;
  int unsigned             idle_cycles = 0;
  int unsigned             burst_left = 0;
  bit                      idle_en = 1'b1;
  bit                      rx_stall_en = 1'b1;
  rx_mode_e                rx_mode = RX_FLOW;
  int unsigned             rx_mode_left = 0;
  int unsigned             rx_stall_left = 0;
  logic [1:0]              rx_tick = '0;

  keyed_event_count_table i_dut (.*);

  always #2 clk_i = ~clk_i;

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_count++;
    if (err_count <= PRINT_LIMIT) begin
      $display("mismatch in %s: got %h, want %h", what, got, want);
    end
  endtask

  function automatic int unsigned table_cap();
    return (limit_reg > KECT_ENTRIES) ? KECT_ENTRIES : int'(limit_reg);
  endfunction

  function automatic tally_t tally_event(event_item_t ev);
    tally_t res;
    int slot;
    res = '0;
    slot = -1;
    if (!ovf_flag && ev.key != '0) begin
      for (int i = 0; i < used_cnt; i++) begin
        if (slot < 0 && key_tbl[i] == ev.key) begin
          slot = i;
        end
      end
      if (slot >= 0) begin
        res.hit = 1'b1;
        if (ev.action == ACT_RECORD) begin
          if (cnt_tbl[slot] != '1) begin
            cnt_tbl[slot] = cnt_tbl[slot] + 1'b1;
          end
          if (ev.update_date && ev.event_date > date_tbl[slot]) begin
            date_tbl[slot] = ev.event_date;
          end
        end
        res.count = cnt_tbl[slot];
        res.date  = date_tbl[slot];
      end else if (ev.action == ACT_RECORD) begin
        if (used_cnt >= table_cap()) begin
          ovf_flag = 1'b1;
        end else begin
          key_tbl[used_cnt]  = ev.key;
          cnt_tbl[used_cnt]  = CNT_W'(1);
          date_tbl[used_cnt] = ev.update_date ? ev.event_date : '0;
          res.count = CNT_W'(1);
          res.date  = date_tbl[used_cnt];
          used_cnt++;
        end
      end
    end
    res.overflowed = ovf_flag;
    return res;
  endfunction

  function automatic event_item_t make_event(action_e a, logic [KEY_W-1:0] k,
                                             logic [DATE_W-1:0] d, logic u);
    event_item_t ev;
    ev.action      = a;
    ev.key         = k;
    ev.event_date  = d;
    ev.update_date = u;
    return ev;
  endfunction

  // Mostly hits on stored keys, some new keys while there is room, some misses
  // and the odd zero key.
  function automatic event_item_t pick_event(bit may_overflow);
    event_item_t ev;
    int unsigned r;
    int unsigned idx;
    ev = make_event(ACT_RECORD, $urandom, $urandom, 1'($urandom_range(0, 1)));
    r = $urandom_range(0, 99);
    if (r < 4) begin
      ev.key    = '0;
      ev.action = action_e'($urandom_range(0, 1));
    end else if (r < 14 || (used_cnt == 0 && !may_overflow && table_cap() == 0)) begin
      ev.action = ACT_QUERY;
    end else if ((r < 26 && (used_cnt < table_cap() || may_overflow)) || used_cnt == 0) begin
      ev.key = ev.key | 32'h1;
      if (used_cnt >= table_cap() && !may_overflow) begin
        ev.action = ACT_QUERY;
      end
    end else begin
      idx = $urandom_range(0, used_cnt - 1);
      ev.key = key_tbl[idx];
      if (r < 40) begin
        ev.action = ACT_QUERY;
      end else if ($urandom_range(0, 1) == 0) begin
        ev.event_date = date_tbl[idx] + 32'($urandom_range(0, 4)) - 32'd2;
      end
    end
    return ev;
  endfunction

  task automatic send_event(event_item_t ev);
    int unsigned gap;
    if (idle_en && burst_left == 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    if (burst_left != 0) begin
      burst_left--;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {ev.event_date, ev.key};
    s_axis_tuser  <= {ev.update_date, ev.action};
    do @(posedge clk_i); while (!s_axis_tready);
    tally_q.push_back(tally_event(ev));
  endtask

  task automatic drain_results(bit settle);
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (tally_q.size() != 0) @(posedge clk_i);
    if (settle) begin
      repeat (SETTLE_CYCLES) @(posedge clk_i);
    end
  endtask

  task automatic check_limit_readback();
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= LIMIT_ADDR;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== 32'(limit_reg)) begin
      report_mismatch("table_limit read", prdata, 32'(limit_reg));
    end
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= LIMIT_ADDR;
    pwdata  <= ($urandom & ~32'h1f) | 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_reg = value;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    check_limit_readback();
  endtask

  task automatic run_limit_phase(logic [LIMIT_W-1:0] value, int unsigned n, bit may_overflow);
    drain_results(1'b1);
    write_limit(value);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == n / 2) begin
        drain_results(1'b0);
      end
      send_event(pick_event(may_overflow));
    end
  endtask

  task automatic test_reset_state();
    check_limit_readback();
    send_event(make_event(ACT_QUERY, 32'h1, 32'h0, 1'b0));
    send_event(make_event(ACT_RECORD, 32'h0, 32'hffff_ffff, 1'b1));
    send_event(make_event(ACT_QUERY, 32'h0, 32'hffff_ffff, 1'b1));
  endtask

  task automatic test_record_and_query();
    send_event(make_event(ACT_RECORD, 32'h1, 32'hffff_ffff, 1'b0));
    send_event(make_event(ACT_RECORD, 32'hffff_ffff, 32'hffff_ffff, 1'b1));
    send_event(make_event(ACT_RECORD, 32'h1, 32'h0, 1'b1));
    send_event(make_event(ACT_RECORD, 32'h1, 32'h5, 1'b1));
    send_event(make_event(ACT_RECORD, 32'h1, 32'h3, 1'b1));
    send_event(make_event(ACT_RECORD, 32'h1, 32'h100, 1'b0));
    send_event(make_event(ACT_QUERY, 32'h1, 32'hffff_ffff, 1'b1));
    send_event(make_event(ACT_QUERY, 32'hffff_ffff, 32'h0, 1'b0));
    send_event(make_event(ACT_QUERY, 32'h2, 32'h0, 1'b0));
    send_event(make_event(ACT_RECORD, 32'hffff_ffff, 32'h0, 1'b1));
    send_event(make_event(ACT_RECORD, 32'h0, 32'hffff_ffff, 1'b1));
    send_event(make_event(ACT_QUERY, 32'h0, 32'h0, 1'b0));
    send_event(make_event(ACT_RECORD, 32'h8000_0000, 32'h7fff_ffff, 1'b1));
    send_event(make_event(ACT_QUERY, 32'h8000_0000, 32'h0, 1'b0));
  endtask

  // The first stored key is found at once, so it is recorded many times in a
  // row without gaps or stalls.
  task automatic test_repeated_record();
    idle_en     = 1'b0;
    rx_stall_en = 1'b0;
    repeat (40) begin
      send_event(make_event(ACT_RECORD, 32'h1, $urandom, 1'($urandom_range(0, 1))));
    end
    send_event(make_event(ACT_QUERY, 32'h1, 32'h0, 1'b0));
    idle_en     = 1'b1;
    rx_stall_en = 1'b1;
  endtask

  // The table only grows, so the limit is raised and lowered around the
  // number of entries in use without ever letting a new key overflow.
  task automatic test_limit_sweep();
    run_limit_phase(5'd4, 80, 1'b0);
    run_limit_phase(5'd1, 50, 1'b0);
    run_limit_phase(5'd0, 40, 1'b0);
    run_limit_phase(5'd10, 100, 1'b0);
    run_limit_phase(5'd31, 150, 1'b0);
  endtask

  task automatic test_overflow_freeze();
    logic [LIMIT_W-1:0] final_limit;
    case ($urandom_range(0, 3))
      0: final_limit = 5'd0;
      1: final_limit = LIMIT_W'($urandom_range(1, 15));
      2: final_limit = 5'd16;
      default: final_limit = 5'd31;
    endcase
    drain_results(1'b1);
    write_limit(final_limit);
    while (!ovf_flag) begin
      send_event(make_event(ACT_RECORD, $urandom | 32'h1, $urandom, 1'($urandom_range(0, 1))));
    end
    send_event(make_event(ACT_RECORD, 32'h0, 32'h0, 1'b0));
    send_event(make_event(ACT_QUERY, key_tbl[0], 32'h0, 1'b0));
    run_limit_phase(5'd16, 60, 1'b1);
  endtask

  always @(negedge clk_i) begin
    if (!rx_stall_en) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = rx_mode_e'($urandom_range(0, 3));
        rx_mode_left = $urandom_range(64, 256);
      end
      rx_mode_left--;
      rx_tick++;
      case (rx_mode)
        RX_FLOW: begin
          m_axis_tready <= 1'b1;
        end
        RX_THREE_IN_FOUR: begin
          m_axis_tready <= (rx_tick != 2'd3);
        end
        RX_COIN: begin
          m_axis_tready <= 1'($urandom_range(0, 1));
        end
        default: begin
          if (rx_stall_left != 0) begin
            rx_stall_left--;
            m_axis_tready <= 1'b0;
          end else if ($urandom_range(0, 7) == 0) begin
            rx_stall_left = $urandom_range(1, 10);
            m_axis_tready <= 1'b0;
          end else begin
            m_axis_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  always @(posedge clk_i) begin : check_results
    tally_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tally_q.size() == 0) begin
        report_mismatch("result with none expected", m_axis_tdata[31:0], '0);
      end else begin
        want = tally_q.pop_front();
        if (m_axis_tuser[0] !== want.hit) begin
          report_mismatch("hit", 32'(m_axis_tuser[0]), 32'(want.hit));
        end
        if (m_axis_tdata[15:0] !== want.count) begin
          report_mismatch("event_count", 32'(m_axis_tdata[15:0]), 32'(want.count));
        end
        if (m_axis_tdata[47:16] !== want.date) begin
          report_mismatch("latest_date", m_axis_tdata[47:16], want.date);
        end
        if (m_axis_tuser[1] !== want.overflowed) begin
          report_mismatch("overflowed", 32'(m_axis_tuser[1]), 32'(want.overflowed));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("keyed_event_count_table regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_reset_state();
    test_record_and_query();
    test_repeated_record();
    test_limit_sweep();
    test_overflow_freeze();
    drain_results(1'b1);
    if (err_count == 0) begin
      $display("keyed_event_count_table regression: pass");
    end else begin
      $display("keyed_event_count_table regression: fail");
    end
    $finish;
  end

endmodule
